// ----- design/binary_morphology_window_defines.svh -----
// Assertion macros shared by the morphology window RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef BINARY_MORPHOLOGY_WINDOW_DEFINES_SVH
`define BINARY_MORPHOLOGY_WINDOW_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define BMW_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define BMW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bmw_pkg.sv -----
// Constants, register codes and record types of the morphology window.
// Used by binary_morphology_window; depends on nothing else.
package bmw_pkg;

    // Sizing of the line store and of the window.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 2;
    localparam int MAX_HEIGHT = 1024;
    localparam int NSLOT      = 2 * MAX_RADIUS + 2;
    localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1;
    localparam int BANK_DEPTH = (MAX_WIDTH + WIN_SIDE - 1) / WIN_SIDE;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int BANK_W     = $clog2(WIN_SIDE);
    localparam int SLOT_W     = $clog2(NSLOT);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Field and register widths.
    localparam int PIX_W      = 8;
    localparam int RADIUS_W   = 2;
    localparam int SIZE_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Widths of derived values.
    localparam int EFF_W   = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;
    localparam int DIST_W  = EFF_W + 2;
    localparam int SLOT_SW = SLOT_W + 2;
    localparam int BANK_SW = BANK_W + 2;
    localparam int LAG_MAX = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
    localparam int WAIT_W  = $clog2(LAG_MAX + 2);

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VALUE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd3;

    // Register reset values.
    localparam logic [RADIUS_W-1:0] KERNEL_RADIUS_RST = 2'd1;
    localparam logic [PIX_W-1:0]    TARGET_VALUE_RST  = 8'd255;
    localparam logic [SIZE_W-1:0]   FRAME_WIDTH_RST   = 11'd320;
    localparam logic [SIZE_W-1:0]   FRAME_HEIGHT_RST  = 11'd240;

    // Raster position with its ring slot and its column bank and bank address.
    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [SLOT_W-1:0]  slot;
        logic [BANK_W-1:0]  bank;
        logic [BANK_AW-1:0] addr;
    } pos_t;

    // Window control carried alongside the line store read.
    typedef struct packed {
        logic [WIN_SIDE-1:0][SLOT_W-1:0] row_slot;
        logic [WIN_SIDE-1:0]             row_ok;
        logic [WIN_SIDE-1:0][BANK_W-1:0] col_bank;
        logic [WIN_SIDE-1:0]             col_ok;
        logic [WIN_SIDE-1:0]             col_hit;
        logic [SLOT_W-1:0]               wr_slot;
        logic                            wr_bit;
        logic                            frame_end;
    } s1_t;

endpackage

// ----- design/binary_morphology_window.sv -----
// Streaming binary dilation and erosion over a 3x3 or 5x5 square window.
// Depends on bmw_pkg and on binary_morphology_window_defines.svh.
//
// Usage:
// Requests enter on item_valid/item_stall with mode and pixel_in; a pixel
// request carries one raster pixel, a drain request carries none and pushes
// out one pending result. Results leave on result_valid/result_stall with
// pixel_out and frame_end. Each channel moves a request at a clock edge where
// valid is high and stall is low.
// A pixel request yields a result once more than R*W+R pixels are pending;
// R*W+R drain requests flush the tail of a frame. A released result is
// registered in the read stage at acceptance and moves on to the output
// register once that is free. Throughput is one request per cycle while
// item_stall is low: the line store is split into one column bank per
// window column, and each bank serves one read and one write per cycle.
// Reset clears the counters, the pipeline and the output register and loads
// the register defaults (radius 1, target 255, 320x240). The line store is
// not cleared; every window bit is written before it is used.
// When the receiver stalls, the output register holds its result and one
// more result may wait in the read stage; item_stall then rises until the
// output register frees.
`include "binary_morphology_window_defines.svh"

module binary_morphology_window (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port.
    input  logic                            cfg_write,
    input  logic [bmw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bmw_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Input requests.
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic                            mode,
    input  logic [bmw_pkg::PIX_W-1:0]       pixel_in,
    // Result requests.
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [bmw_pkg::PIX_W-1:0]       pixel_out,
    output logic                            frame_end
);

    // Configuration registers.
    logic [bmw_pkg::RADIUS_W-1:0] kernel_radius_reg;
    logic [bmw_pkg::PIX_W-1:0]    target_value_reg;
    logic [bmw_pkg::SIZE_W-1:0]   frame_width_reg;
    logic [bmw_pkg::SIZE_W-1:0]   frame_height_reg;

    // Effective sizes and output lag.
    logic [bmw_pkg::RADIUS_W-1:0] r_eff;
    logic [bmw_pkg::EFF_W-1:0]    w_eff;
    logic [bmw_pkg::EFF_W-1:0]    h_eff;
    logic [bmw_pkg::WAIT_W-1:0]   lag;

    // Raster counters and pending count.
    bmw_pkg::pos_t              in_pos_reg, in_pos_next;
    bmw_pkg::pos_t              out_pos_reg, out_pos_next;
    logic [bmw_pkg::WAIT_W-1:0] waiting_reg, waiting_next;
    logic [bmw_pkg::WAIT_W-1:0] wait_plus;

    // Handshake and control.
    logic accept;
    logic is_pixel;
    logic emit;
    logic wr_en;
    logic wr_bit;
    logic rd_en;
    logic frame_last;
    logic out_free;
    logic s1_move;

    // Line store: one bank per window column, one bit per ring slot.
    logic [bmw_pkg::NSLOT-1:0] bank_mem [bmw_pkg::WIN_SIDE][bmw_pkg::BANK_DEPTH];
    logic [bmw_pkg::WIN_SIDE-1:0][bmw_pkg::NSLOT-1:0]   rdata_reg;
    logic [bmw_pkg::WIN_SIDE-1:0][bmw_pkg::BANK_AW-1:0] rd_addr;

    // Read stage.
    logic        s1_valid_reg, s1_valid_next;
    bmw_pkg::s1_t s1_reg, s1_next;
    logic        win_hit;

    // Output register.
    logic                      result_valid_reg, result_valid_next;
    logic [bmw_pkg::PIX_W-1:0] pixel_out_reg;
    logic                      frame_end_reg;

    // Step a raster position by one pixel, wrapping column, row and slot.
    function automatic bmw_pkg::pos_t step_pos(
        input bmw_pkg::pos_t             p,
        input logic [bmw_pkg::EFF_W-1:0] w,
        input logic [bmw_pkg::EFF_W-1:0] h
    );
        bmw_pkg::pos_t          n;
        logic [bmw_pkg::COL_W:0] col_inc;
        logic [bmw_pkg::ROW_W:0] row_inc;
        n       = p;
        col_inc = {1'b0, p.col} + 1'b1;
        row_inc = {1'b0, p.row} + 1'b1;
        if (bmw_pkg::EFF_W'(col_inc) >= w)
        begin
            n.col  = '0;
            n.bank = '0;
            n.addr = '0;
            n.slot = (p.slot == bmw_pkg::SLOT_W'(bmw_pkg::NSLOT - 1)) ? '0 : p.slot + 1'b1;
            n.row  = (bmw_pkg::EFF_W'(row_inc) >= h) ? '0 : row_inc[bmw_pkg::ROW_W-1:0];
        end
        else
        begin
            n.col = col_inc[bmw_pkg::COL_W-1:0];
            if (p.bank == bmw_pkg::BANK_W'(bmw_pkg::WIN_SIDE - 1))
            begin
                n.bank = '0;
                n.addr = p.addr + 1'b1;
            end
            else
            begin
                n.bank = p.bank + 1'b1;
            end
        end
        return n;
    endfunction

    // Clamp the registers to their working ranges.
    always_comb
    begin
        if (kernel_radius_reg == '0)
            r_eff = bmw_pkg::RADIUS_W'(1);
        else if (int'(kernel_radius_reg) > bmw_pkg::MAX_RADIUS)
            r_eff = bmw_pkg::RADIUS_W'(bmw_pkg::MAX_RADIUS);
        else
            r_eff = kernel_radius_reg;

        if (frame_width_reg == '0)
            w_eff = bmw_pkg::EFF_W'(1);
        else if (bmw_pkg::EFF_W'(frame_width_reg) > bmw_pkg::EFF_W'(bmw_pkg::MAX_WIDTH))
            w_eff = bmw_pkg::EFF_W'(bmw_pkg::MAX_WIDTH);
        else
            w_eff = bmw_pkg::EFF_W'(frame_width_reg);

        if (frame_height_reg == '0)
            h_eff = bmw_pkg::EFF_W'(1);
        else if (bmw_pkg::EFF_W'(frame_height_reg) > bmw_pkg::EFF_W'(bmw_pkg::MAX_HEIGHT))
            h_eff = bmw_pkg::EFF_W'(bmw_pkg::MAX_HEIGHT);
        else
            h_eff = bmw_pkg::EFF_W'(frame_height_reg);
    end

    assign lag = bmw_pkg::WAIT_W'(r_eff) * bmw_pkg::WAIT_W'(w_eff) + bmw_pkg::WAIT_W'(r_eff);

    // Handshake: the read stage holds only while the output register is blocked.
    assign out_free   = !result_valid_reg || !result_stall;
    assign s1_move    = s1_valid_reg && out_free;
    assign item_stall = s1_valid_reg && !out_free;
    assign accept     = item_valid && !item_stall;

    // Decide whether this request releases a result.
    assign is_pixel  = (mode == 1'b0);
    assign wait_plus = waiting_reg + 1'b1;
    assign emit      = is_pixel ? (wait_plus > lag) : (waiting_reg != '0);
    assign wr_en     = accept && is_pixel;
    assign wr_bit    = (pixel_in == target_value_reg);
    assign rd_en     = accept && emit;
    assign frame_last = (bmw_pkg::EFF_W'(out_pos_reg.row) == h_eff - 1'b1) &&
                        (bmw_pkg::EFF_W'(out_pos_reg.col) == w_eff - 1'b1);

    // Counter and pending count updates.
    always_comb
    begin
        in_pos_next  = in_pos_reg;
        out_pos_next = out_pos_reg;
        waiting_next = waiting_reg;
        if (accept)
        begin
            if (is_pixel)
            begin
                in_pos_next  = step_pos(in_pos_reg, w_eff, h_eff);
                waiting_next = emit ? waiting_reg : wait_plus;
            end
            else if (emit)
            begin
                waiting_next = waiting_reg - 1'b1;
            end
            if (emit)
                out_pos_next = step_pos(out_pos_reg, w_eff, h_eff);
        end
    end

    // Window setup: row slots, column banks, border masks and write forwarding.
    always_comb
    begin
        logic signed [bmw_pkg::DIST_W-1:0]  rr;
        logic signed [bmw_pkg::DIST_W-1:0]  cc;
        logic signed [bmw_pkg::SLOT_SW-1:0] sv;
        logic signed [bmw_pkg::BANK_SW-1:0] u;
        logic [bmw_pkg::BANK_W-1:0]         bank;
        logic [bmw_pkg::BANK_AW-1:0]        addr;
        logic                               in_radius;
        s1_next = s1_reg;
        rd_addr = '0;
        for (int j = 0; j < bmw_pkg::WIN_SIDE; j++)
        begin
            in_radius = (j >= bmw_pkg::MAX_RADIUS - int'(r_eff)) &&
                        (j <= bmw_pkg::MAX_RADIUS + int'(r_eff));

            // Row offset j - MAX_RADIUS.
            rr = $signed({{(bmw_pkg::DIST_W - bmw_pkg::ROW_W){1'b0}}, out_pos_reg.row}) +
                 bmw_pkg::DIST_W'(j - bmw_pkg::MAX_RADIUS);
            s1_next.row_ok[j] = in_radius && (rr >= 0) && (rr < $signed({2'b00, h_eff}));
            sv = $signed({2'b00, out_pos_reg.slot}) + bmw_pkg::SLOT_SW'(j - bmw_pkg::MAX_RADIUS);
            if (sv < 0)
                sv = sv + bmw_pkg::SLOT_SW'(bmw_pkg::NSLOT);
            else if (sv >= bmw_pkg::SLOT_SW'(bmw_pkg::NSLOT))
                sv = sv - bmw_pkg::SLOT_SW'(bmw_pkg::NSLOT);
            s1_next.row_slot[j] = sv[bmw_pkg::SLOT_W-1:0];

            // Column offset j - MAX_RADIUS.
            cc = $signed({{(bmw_pkg::DIST_W - bmw_pkg::COL_W){1'b0}}, out_pos_reg.col}) +
                 bmw_pkg::DIST_W'(j - bmw_pkg::MAX_RADIUS);
            s1_next.col_ok[j] = in_radius && (cc >= 0) && (cc < $signed({2'b00, w_eff}));
            u = $signed({2'b00, out_pos_reg.bank}) + bmw_pkg::BANK_SW'(j - bmw_pkg::MAX_RADIUS);
            if (u < 0)
            begin
                u    = u + bmw_pkg::BANK_SW'(bmw_pkg::WIN_SIDE);
                addr = out_pos_reg.addr - 1'b1;
            end
            else if (u >= bmw_pkg::BANK_SW'(bmw_pkg::WIN_SIDE))
            begin
                u    = u - bmw_pkg::BANK_SW'(bmw_pkg::WIN_SIDE);
                addr = out_pos_reg.addr + 1'b1;
            end
            else
            begin
                addr = out_pos_reg.addr;
            end
            bank                = u[bmw_pkg::BANK_W-1:0];
            s1_next.col_bank[j] = bank;
            rd_addr[bank]       = addr;

            // The pixel written in this cycle is not yet visible in the read data.
            s1_next.col_hit[j] = wr_en && (bank == in_pos_reg.bank) && (addr == in_pos_reg.addr);
        end
        s1_next.wr_slot   = in_pos_reg.slot;
        s1_next.wr_bit    = wr_bit;
        s1_next.frame_end = frame_last;
    end

    // Line store banks: bit write of the new pixel, registered column read.
    always_ff @(posedge clk)
    begin
        for (int b = 0; b < bmw_pkg::WIN_SIDE; b++)
        begin
            if (wr_en && (in_pos_reg.bank == bmw_pkg::BANK_W'(b)))
                bank_mem[b][in_pos_reg.addr][in_pos_reg.slot] <= wr_bit;
            if (rd_en)
                rdata_reg[b] <= bank_mem[b][rd_addr[b]];
        end
    end

    // Read stage: patch the forwarded bit and reduce the window.
    always_comb
    begin
        logic [bmw_pkg::NSLOT-1:0] word;
        win_hit = 1'b0;
        for (int j = 0; j < bmw_pkg::WIN_SIDE; j++)
        begin
            word = rdata_reg[s1_reg.col_bank[j]];
            if (s1_reg.col_hit[j])
                word[s1_reg.wr_slot] = s1_reg.wr_bit;
            for (int k = 0; k < bmw_pkg::WIN_SIDE; k++)
                win_hit = win_hit | (word[s1_reg.row_slot[k]] & s1_reg.row_ok[k] &
                                     s1_reg.col_ok[j]);
        end
    end

    // Valid flags of the read stage and the output register.
    always_comb
    begin
        if (rd_en)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_move)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_radius_reg <= bmw_pkg::KERNEL_RADIUS_RST;
            target_value_reg  <= bmw_pkg::TARGET_VALUE_RST;
            frame_width_reg   <= bmw_pkg::FRAME_WIDTH_RST;
            frame_height_reg  <= bmw_pkg::FRAME_HEIGHT_RST;
            in_pos_reg        <= '0;
            out_pos_reg       <= '0;
            waiting_reg       <= '0;
            s1_valid_reg      <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    bmw_pkg::CFG_KERNEL_RADIUS:
                        kernel_radius_reg <= cfg_data[bmw_pkg::RADIUS_W-1:0];
                    bmw_pkg::CFG_TARGET_VALUE:
                        target_value_reg <= cfg_data[bmw_pkg::PIX_W-1:0];
                    bmw_pkg::CFG_FRAME_WIDTH:
                        frame_width_reg <= cfg_data[bmw_pkg::SIZE_W-1:0];
                    bmw_pkg::CFG_FRAME_HEIGHT:
                        frame_height_reg <= cfg_data[bmw_pkg::SIZE_W-1:0];
                    default:
                        ;
                endcase
            end
            in_pos_reg       <= in_pos_next;
            out_pos_reg      <= out_pos_next;
            waiting_reg      <= waiting_next;
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (rd_en)
            s1_reg <= s1_next;
        if (s1_move)
        begin
            pixel_out_reg <= win_hit ? target_value_reg : bmw_pkg::PIX_MAX - target_value_reg;
            frame_end_reg <= s1_reg.frame_end;
        end
    end

    assign result_valid = result_valid_reg;
    assign pixel_out    = pixel_out_reg;
    assign frame_end    = frame_end_reg;

    // A blocked read stage keeps its result.
    `BMW_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !out_free, s1_valid_reg, "read stage lost a result")
    // A released result always reaches the read stage.
    `BMW_ASSERT_NEXT(a_s1_fill, rd_en, s1_valid_reg, "released result missing in read stage")
    // Ring slots and column banks stay inside their ranges.
    `BMW_ASSERT_ALWAYS(a_ring_range, (in_pos_reg.slot < bmw_pkg::NSLOT) && (out_pos_reg.slot < bmw_pkg::NSLOT) && (in_pos_reg.bank < bmw_pkg::WIN_SIDE) && (out_pos_reg.bank < bmw_pkg::WIN_SIDE), "ring slot or bank out of range")
    // The last result of a frame returns the output position to the origin.
    `BMW_ASSERT_NEXT(a_frame_wrap, rd_en && frame_last, (out_pos_reg.row == '0) && (out_pos_reg.col == '0), "output position did not wrap at frame end")

endmodule
